@@ sv/ctok_pkg.sv @@
// ============================================================================
// ctok_pkg: shared types, codes and character helpers
// Holds the result record, parser phases, status codes and the character
// classification functions used by the call expression tokenizer.
// ============================================================================
`default_nettype none

package ctok_pkg;

    // Default sizes for the top-level parameters.
    localparam int STORAGE_BYTES_DEF = 256;
    localparam int MAX_PARAMS_DEF    = 8;

    // Output queue: depth and the most results one character can cause.
    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_AW    = 3;
    localparam int RES_MAX    = 3;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_LEAD,
        PH_NAME,
        PH_PLEAD,
        PH_PARAM,
        PH_PWS,
        PH_WS,
        PH_STR,
        PH_ESC,
        PH_HEX1,
        PH_HEX2,
        PH_TRAIL,
        PH_ERR
    } t_phase;

    // Status codes; each line reports one, at its terminator or its first error.
    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_TWO_DOTS   = 4'd1;
    localparam logic [3:0] ST_BAD_NAME   = 4'd2;
    localparam logic [3:0] ST_NO_PAREN   = 4'd3;
    localparam logic [3:0] ST_TOO_MANY   = 4'd4;
    localparam logic [3:0] ST_NO_CLOSE   = 4'd5;
    localparam logic [3:0] ST_TRAILING   = 4'd6;
    localparam logic [3:0] ST_WHITESPACE = 4'd7;
    localparam logic [3:0] ST_STR_IDENT  = 4'd8;
    localparam logic [3:0] ST_BAD_CHAR   = 4'd9;
    localparam logic [3:0] ST_EMPTY      = 4'd10;
    localparam logic [3:0] ST_DOT_NO_SYS = 4'd11;
    localparam logic [3:0] ST_NO_FUNC    = 4'd12;
    localparam logic [3:0] ST_NO_STORAGE = 4'd13;

    // Section codes of stored bytes.
    localparam logic [1:0] SEC_FIRST = 2'd0;
    localparam logic [1:0] SEC_FUNC  = 2'd1;
    localparam logic [1:0] SEC_PARAM = 2'd2;

    // Characters with a meaning to the parser.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_X      = 8'h78;

    // One result record; last marks the final record of a character.
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] stored_byte;
        logic [7:0] store_address;
        logic [1:0] section;
        logic [2:0] param_index;
        logic       done_res;
        logic [3:0] status;
        logic [3:0] param_count;
        logic       has_system;
        logic       last;
    } t_res;

    function automatic logic is_ws(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic is_name(logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h30) && (c <= 8'h39)) || (c == CH_UNDER);
    endfunction

    // Hex digit value; anything that is not a hex digit counts as zero.
    function automatic logic [3:0] hex_val(logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            v = 4'(c - 8'h30);
        end else if ((c >= 8'h41) && (c <= 8'h46)) begin
            v = 4'(c - 8'h37);
        end else if ((c >= 8'h61) && (c <= 8'h66)) begin
            v = 4'(c - 8'h57);
        end
        return v;
    endfunction

    // C escape letters; an unknown escape stands for the character itself.
    function automatic logic [7:0] escape_map(logic [7:0] e);
        logic [7:0] v;
        unique case (e)
            8'h6E: v = 8'h0A;
            8'h72: v = 8'h0D;
            8'h61: v = 8'h07;
            8'h62: v = 8'h08;
            8'h66: v = 8'h0C;
            8'h74: v = 8'h09;
            8'h76: v = 8'h0B;
            default: v = e;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ sv/ctok_outq.sv @@
// ============================================================================
// ctok_outq: result queue
// Eight-entry queue that takes up to three results in one cycle and hands
// them out one transfer at a time; room means space for three more.
// ============================================================================
`default_nettype none

module ctok_outq (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic [1:0]                              i_wr_cnt,
    input  wire ctok_pkg::t_res [ctok_pkg::RES_MAX-1:0]  i_wr_data,
    output logic                                         o_room,
    output logic                                         o_tvalid,
    input  wire logic                                    i_tready,
    output ctok_pkg::t_res                               o_head
);

    localparam int CntW = $clog2(ctok_pkg::OUTQ_DEPTH + 1);
    localparam logic [CntW-1:0] RoomLim = CntW'(ctok_pkg::OUTQ_DEPTH - ctok_pkg::RES_MAX);
    localparam logic [CntW-1:0] DepthC  = CntW'(ctok_pkg::OUTQ_DEPTH);

    ctok_pkg::t_res                 r_mem [ctok_pkg::OUTQ_DEPTH];
    logic [ctok_pkg::OUTQ_AW-1:0]   r_wptr;
    logic [ctok_pkg::OUTQ_AW-1:0]   r_rptr;
    logic [CntW-1:0]                r_cnt;
    logic [CntW-1:0]                n_cnt;
    logic                           pop;

    assign pop      = o_tvalid & i_tready;
    assign o_tvalid = (r_cnt != '0);
    assign o_room   = (r_cnt <= RoomLim);
    assign o_head   = r_mem[r_rptr];
    assign n_cnt    = r_cnt + CntW'(i_wr_cnt) - CntW'(pop);

    // Entry storage: write up to three consecutive slots.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ctok_pkg::RES_MAX; i++) begin
            if (2'(i) < i_wr_cnt) begin
                r_mem[r_wptr + ctok_pkg::OUTQ_AW'(i)] <= i_wr_data[i];
            end
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= r_wptr + ctok_pkg::OUTQ_AW'(i_wr_cnt);
            r_rptr <= r_rptr + ctok_pkg::OUTQ_AW'(pop);
            r_cnt  <= n_cnt;
        end
    end

    // Queue never overfills.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DepthC)
        else $error("result queue count above depth");

    // A write only arrives when room for three was offered.
    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr_cnt != 2'd0) |-> o_room)
        else $error("result queue written without room");

    // A write into an empty queue shows a result next cycle.
    a_write_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 && i_wr_cnt != 2'd0) |=> o_tvalid)
        else $error("written result not presented");

endmodule

`default_nettype wire

@@ sv/call_expression_tokenizer_core.sv @@
// ============================================================================
// call_expression_tokenizer_core: call expression tokenizer
// Parses [system.]function(param, "string", ...) one character a transfer,
// emitting each stored byte with its address, section and parameter index,
// and one status result per line.
// ============================================================================
// A result put into an empty queue is shown the cycle after its transfer.
// Throughput: one character per cycle; a character that causes two or three
// results occupies the output for that many transfers, and the input is
// held off while the eight-entry result queue has fewer than three free.
// Reset: synchronous, active low; clears the parser state and result queue.
// No memory is cleared; the block takes characters right after reset.
`default_nettype none

module call_expression_tokenizer_core #(
    parameter int STORAGE_BYTES = ctok_pkg::STORAGE_BYTES_DEF,
    parameter int MAX_PARAMS    = ctok_pkg::MAX_PARAMS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] ch
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [7:0] stored_byte, [15:8] store_address, [17:16] section,
    // [20:18] param_index, [24:21] status, [28:25] param_count,
    // [29] has_system, [31:30] zero
    output logic [31:0]      o_m_axis_tdata,
    output logic [1:0]       o_m_axis_tuser,   // [0] byte_valid, [1] done_res
    output logic             o_m_axis_tlast
);

    localparam int PosW = $clog2(STORAGE_BYTES);
    localparam int PnW  = $clog2(MAX_PARAMS + 1);
    localparam logic [PosW-1:0] PosLim = PosW'(STORAGE_BYTES - 1);
    localparam logic [PnW-1:0]  MaxPn  = PnW'(MAX_PARAMS);

    typedef struct packed {
        ctok_pkg::t_phase  phase;
        logic [PosW-1:0]   pos;
        logic [PnW-1:0]    pn;
        logic              nht;   // name has text
        logic              sd;    // seen dot
        logic              pht;   // param has text
        logic              pis;   // param is string
        logic              sov;   // string overflow
        logic [7:0]        held;  // first hex digit
        logic              pst;   // param started
    } t_state;

    // Working record of one character pass.
    typedef struct packed {
        t_state                 s;
        ctok_pkg::t_res [1:0]   r;
        logic [1:0]             n;
        logic                   ok;
    } t_proc;

    t_state              r_st;
    t_state              n_st;
    t_proc               pr [3];
    ctok_pkg::t_res [2:0] q;
    logic [1:0]          qn;
    logic [1:0]          wr_cnt;
    logic                accept;
    logic                bad1;
    logic                bad2;
    logic                room;
    logic [7:0]          c;
    ctok_pkg::t_res      head;

    // ------------------------------------------------------------------
    // Parser helpers
    // ------------------------------------------------------------------
    function automatic t_state f_clear();
        t_state s;
        s = '0;
        s.phase = ctok_pkg::PH_LEAD;
        return s;
    endfunction

    function automatic t_proc f_fresh(t_state s);
        t_proc p;
        p = '0;
        p.s = s;
        return p;
    endfunction

    function automatic t_proc f_store(t_proc p, logic [7:0] b, logic [1:0] sec);
        ctok_pkg::t_res r;
        r = '0;
        p.ok = 1'b0;
        if (p.s.pos < PosLim) begin
            r.byte_valid    = 1'b1;
            r.stored_byte   = b;
            r.store_address = 8'(p.s.pos);
            r.section       = sec;
            r.param_index   = (sec == ctok_pkg::SEC_PARAM) ? 3'(p.s.pn) : 3'd0;
            p.r[p.n[0]]     = r;
            p.n             = p.n + 2'd1;
            p.s.pos         = p.s.pos + PosW'(1);
            p.ok            = 1'b1;
        end
        return p;
    endfunction

    function automatic t_proc f_finish(t_proc p, logic [3:0] st);
        ctok_pkg::t_res r;
        r = '0;
        p.s.phase     = ctok_pkg::PH_ERR;
        r.done_res    = 1'b1;
        r.status      = st;
        r.param_count = (st == ctok_pkg::ST_OK) ? 4'(p.s.pn) : 4'd0;
        r.has_system  = p.s.sd;
        p.r[p.n[0]]   = r;
        p.n           = p.n + 2'd1;
        return p;
    endfunction

    function automatic t_proc f_param_store(t_proc p, logic [7:0] b);
        p = f_store(p, b, ctok_pkg::SEC_PARAM);
        if (p.ok) begin
            if (!p.s.pst) begin
                p.s.pst = 1'b1;
                p.s.pht = (b != ctok_pkg::CH_NUL);
            end
        end else begin
            p.s.sov = 1'b1;
        end
        return p;
    endfunction

    function automatic t_proc f_string_char(t_proc p, logic [7:0] ch);
        if (ch == ctok_pkg::CH_NUL) begin
            p = f_finish(p, p.s.sov ? ctok_pkg::ST_NO_STORAGE : ctok_pkg::ST_NO_CLOSE);
        end else if (ch == ctok_pkg::CH_QUOTE) begin
            if (p.s.sov) p = f_finish(p, ctok_pkg::ST_NO_STORAGE);
            else p.s.phase = ctok_pkg::PH_PARAM;
        end else if (ch == ctok_pkg::CH_BSLASH) begin
            p.s.phase = ctok_pkg::PH_ESC;
        end else begin
            p = f_param_store(p, ch);
        end
        return p;
    endfunction

    function automatic t_proc f_escape_char(t_proc p, logic [7:0] e);
        if (e == ctok_pkg::CH_NUL) begin
            p = f_finish(p, p.s.sov ? ctok_pkg::ST_NO_STORAGE : ctok_pkg::ST_NO_CLOSE);
        end else if (e == ctok_pkg::CH_X) begin
            p.s.phase = ctok_pkg::PH_HEX1;
        end else begin
            p.s.phase = ctok_pkg::PH_STR;
            p = f_param_store(p, ctok_pkg::escape_map(e));
        end
        return p;
    endfunction

    // Close a parameter at a comma or the closing parenthesis.
    function automatic t_proc f_end_param(t_proc p, logic closing);
        if (!p.s.pis && !p.s.pht) begin
            p = f_finish(p, ctok_pkg::ST_EMPTY);
        end else begin
            p = f_store(p, ctok_pkg::CH_NUL, ctok_pkg::SEC_PARAM);
            if (!p.ok) begin
                p = f_finish(p, ctok_pkg::ST_NO_STORAGE);
            end else begin
                p.s.pn  = p.s.pn + PnW'(1);
                p.s.pis = 1'b0;
                p.s.pst = 1'b0;
                p.s.pht = 1'b0;
                if (closing) p.s.phase = ctok_pkg::PH_TRAIL;
                else if (p.s.pn == MaxPn) p = f_finish(p, ctok_pkg::ST_TOO_MANY);
                else p.s.phase = ctok_pkg::PH_PWS;
            end
        end
        return p;
    endfunction

    function automatic t_proc f_param_char(t_proc p, logic [7:0] ch);
        if (ch == ctok_pkg::CH_QUOTE) begin
            p.s.pis = 1'b1;
            if (p.s.pht) begin
                p = f_finish(p, ctok_pkg::ST_STR_IDENT);
            end else begin
                p.s.sov   = 1'b0;
                p.s.phase = ctok_pkg::PH_STR;
            end
        end else if (ch == ctok_pkg::CH_COMMA) begin
            p = f_end_param(p, 1'b0);
        end else if (ch == ctok_pkg::CH_RPAREN) begin
            p = f_end_param(p, 1'b1);
        end else if (ch == ctok_pkg::CH_NUL) begin
            p = f_finish(p, ctok_pkg::ST_NO_CLOSE);
        end else if (ch == ctok_pkg::CH_LPAREN || ch == ctok_pkg::CH_SEMI) begin
            p = f_finish(p, ctok_pkg::ST_BAD_CHAR);
        end else if (ctok_pkg::is_ws(ch)) begin
            p.s.phase = ctok_pkg::PH_WS;
        end else if (p.s.pis) begin
            p = f_finish(p, ctok_pkg::ST_STR_IDENT);
        end else begin
            p = f_store(p, ch, ctok_pkg::SEC_PARAM);
            if (!p.ok) begin
                p = f_finish(p, ctok_pkg::ST_NO_STORAGE);
            end else if (!p.s.pst) begin
                p.s.pst = 1'b1;
                p.s.pht = 1'b1;
            end
        end
        return p;
    endfunction

    function automatic t_proc f_name_char(t_proc p, logic [7:0] ch);
        logic [1:0] sec;
        sec = p.s.sd ? ctok_pkg::SEC_FUNC : ctok_pkg::SEC_FIRST;
        if (ctok_pkg::is_name(ch)) begin
            p = f_store(p, ch, sec);
            if (!p.ok) p = f_finish(p, ctok_pkg::ST_NO_STORAGE);
            else p.s.nht = 1'b1;
        end else if (ch == ctok_pkg::CH_DOT) begin
            if (p.s.sd) begin
                p = f_finish(p, ctok_pkg::ST_TWO_DOTS);
            end else if (!p.s.nht) begin
                p = f_finish(p, ctok_pkg::ST_DOT_NO_SYS);
            end else begin
                p = f_store(p, ctok_pkg::CH_NUL, ctok_pkg::SEC_FIRST);
                if (!p.ok) begin
                    p = f_finish(p, ctok_pkg::ST_NO_STORAGE);
                end else begin
                    p.s.sd  = 1'b1;
                    p.s.nht = 1'b0;
                end
            end
        end else if (ch == ctok_pkg::CH_LPAREN) begin
            if (!p.s.nht) begin
                p = f_finish(p, ctok_pkg::ST_NO_FUNC);
            end else begin
                p = f_store(p, ctok_pkg::CH_NUL, sec);
                if (!p.ok) p = f_finish(p, ctok_pkg::ST_NO_STORAGE);
                else p.s.phase = ctok_pkg::PH_PLEAD;
            end
        end else if (ch == ctok_pkg::CH_NUL) begin
            p = f_finish(p, ctok_pkg::ST_NO_PAREN);
        end else begin
            p = f_finish(p, ctok_pkg::ST_BAD_NAME);
        end
        return p;
    endfunction

    // One character in the current phase. The hex phases here take the
    // ordinary case; a quote or terminator after \x is split up by the caller.
    function automatic t_proc f_proc(t_proc p, logic [7:0] ch);
        unique case (p.s.phase)
            ctok_pkg::PH_LEAD: begin
                if (!ctok_pkg::is_ws(ch)) begin
                    p.s.phase = ctok_pkg::PH_NAME;
                    p = f_name_char(p, ch);
                end
            end
            ctok_pkg::PH_NAME: p = f_name_char(p, ch);
            ctok_pkg::PH_PLEAD: begin
                if (ctok_pkg::is_ws(ch)) begin
                    p.s.phase = ctok_pkg::PH_PLEAD;
                end else if (ch == ctok_pkg::CH_RPAREN) begin
                    p.s.pn    = '0;
                    p.s.phase = ctok_pkg::PH_TRAIL;
                end else begin
                    p.s.phase = ctok_pkg::PH_PARAM;
                    p = f_param_char(p, ch);
                end
            end
            ctok_pkg::PH_PARAM: p = f_param_char(p, ch);
            ctok_pkg::PH_PWS: begin
                if (!ctok_pkg::is_ws(ch)) begin
                    p.s.phase = ctok_pkg::PH_PARAM;
                    p = f_param_char(p, ch);
                end
            end
            ctok_pkg::PH_WS: begin
                if (ctok_pkg::is_ws(ch)) begin
                    p.s.phase = ctok_pkg::PH_WS;
                end else if (ch == ctok_pkg::CH_COMMA || ch == ctok_pkg::CH_RPAREN ||
                             ch == ctok_pkg::CH_NUL) begin
                    p.s.phase = ctok_pkg::PH_PARAM;
                    p = f_param_char(p, ch);
                end else begin
                    p = f_finish(p, ctok_pkg::ST_WHITESPACE);
                end
            end
            ctok_pkg::PH_STR: p = f_string_char(p, ch);
            ctok_pkg::PH_ESC: p = f_escape_char(p, ch);
            ctok_pkg::PH_HEX1: begin
                p.s.held  = ch;
                p.s.phase = ctok_pkg::PH_HEX2;
            end
            ctok_pkg::PH_HEX2: begin
                p.s.phase = ctok_pkg::PH_STR;
                p = f_param_store(p, {ctok_pkg::hex_val(p.s.held), ctok_pkg::hex_val(ch)});
            end
            ctok_pkg::PH_TRAIL: begin
                if (ch == ctok_pkg::CH_NUL) p = f_finish(p, ctok_pkg::ST_OK);
                else if (!ctok_pkg::is_ws(ch)) p = f_finish(p, ctok_pkg::ST_TRAILING);
            end
            default: p.s.phase = p.s.phase;
        endcase
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Character processing
    // ------------------------------------------------------------------
    assign c      = i_s_axis_tdata;
    assign accept = i_s_axis_tvalid & room;
    assign bad1   = (r_st.phase == ctok_pkg::PH_HEX1) &&
                    (c == ctok_pkg::CH_NUL || c == ctok_pkg::CH_QUOTE);
    assign bad2   = (r_st.phase == ctok_pkg::PH_HEX2) &&
                    (c == ctok_pkg::CH_NUL || c == ctok_pkg::CH_QUOTE);

    // An \x cut short stores 'x' and reads any held digit and this character
    // again as string text, which takes up to three passes.
    always_comb begin
        t_state s0;
        s0 = r_st;
        if (bad1 || bad2) begin
            s0.phase = ctok_pkg::PH_STR;
            pr[0] = f_proc(f_fresh(s0), ctok_pkg::CH_X);
            pr[1] = f_proc(f_fresh(pr[0].s), bad2 ? r_st.held : c);
            pr[2] = bad2 ? f_proc(f_fresh(pr[1].s), c) : f_fresh(pr[1].s);
        end else begin
            pr[0] = f_proc(f_fresh(s0), c);
            pr[1] = f_fresh(pr[0].s);
            pr[2] = f_fresh(pr[1].s);
        end
    end

    // Gather the results of all passes in order and mark the last one.
    always_comb begin
        q  = '0;
        qn = 2'd0;
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 2; j++) begin
                if (2'(j) < pr[k].n && qn < 2'd3) begin
                    q[qn] = pr[k].r[j];
                    qn    = qn + 2'd1;
                end
            end
        end
        if (qn != 2'd0) begin
            q[qn - 2'd1].last = 1'b1;
        end
    end

    // Next parser state; a terminator always starts a fresh line.
    always_comb begin
        n_st = r_st;
        if (accept) begin
            n_st = (c == ctok_pkg::CH_NUL) ? f_clear() : pr[2].s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= f_clear();
        end else begin
            r_st <= n_st;
        end
    end

    assign wr_cnt = accept ? qn : 2'd0;

    // ------------------------------------------------------------------
    // Result queue and output packing
    // ------------------------------------------------------------------
    ctok_outq u_outq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_cnt  (wr_cnt),
        .i_wr_data (q),
        .o_room    (room),
        .o_tvalid  (o_m_axis_tvalid),
        .i_tready  (i_m_axis_tready),
        .o_head    (head)
    );

    assign o_s_axis_tready = room;
    assign o_m_axis_tdata  = {2'b00, head.has_system, head.param_count, head.status,
                              head.param_index, head.section, head.store_address,
                              head.stored_byte};
    assign o_m_axis_tuser  = {head.done_res, head.byte_valid};
    assign o_m_axis_tlast  = head.last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_nul_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && c == ctok_pkg::CH_NUL) |=>
            (r_st.phase == ctok_pkg::PH_LEAD && r_st.pos == '0 && r_st.pn == '0))
        else $error("terminator did not restart the parser");

    a_err_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_st.phase == ctok_pkg::PH_ERR) |-> (wr_cnt == 2'd0))
        else $error("result produced after a status");

    a_err_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_st.phase == ctok_pkg::PH_ERR && c != ctok_pkg::CH_NUL) |=>
            $stable(r_st))
        else $error("parser state moved while skipping to terminator");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.pos <= PosLim) && (r_st.pn <= MaxPn))
        else $error("store position or parameter count out of range");

endmodule

`default_nettype wire
